@@ hw/rtl/salc_pkg.sv @@
// Shared types and constants for the set-associative LRU cache tag model.
// Used by set_assoc_lru_cache_model; depends on nothing else.
`default_nettype none

package salc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS        = 2'd2;

  localparam int CFG_DATA_W  = 5;
  localparam int SET_REG_W   = 3;
  localparam int OFF_REG_W   = 5;
  localparam int WAYS_REG_W  = 4;

  localparam logic [OFF_REG_W-1:0] OFFSET_MIN = 5'd1;
  localparam logic [OFF_REG_W-1:0] OFFSET_MAX = 5'd16;

  localparam logic [SET_REG_W-1:0]  SET_BITS_RESET = 3'd1;
  localparam logic [OFF_REG_W-1:0]  OFFSET_RESET   = 5'd4;
  localparam logic [WAYS_REG_W-1:0] WAYS_RESET     = 4'd1;

  localparam int TOTAL_W = 32;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

@@ hw/rtl/set_assoc_lru_cache_model.sv @@
// Set-associative cache tag store with LRU replacement and hit, miss and eviction totals.
// Depends on salc_pkg for the sequencer states, register indexes and constants.
//
// Usage: an input word (command, address) is taken when in_valid is high and in_stall
// is low. Command 0 gives one access result, command 1 (modify) gives two, the second
// with last set. Each result word waits in an output register until out_valid is high
// and out_stall is low; the totals shown are those after that access.
// Each access scans the ways in use of its set one per cycle through a tag memory with
// one read port and one shared tag and stamp compare; a modify scans its set again for
// its second result. Input is accepted again in the cycle after the last update.
// A result can only be loaded when the output register is empty or being taken, so a
// stalled receiver holds the block in its update step.
// After reset a clearing pass writes every line of the memory invalid, one line per
// cycle, (2^MAX_SET_BITS)*MAX_WAYS lines (512 by default); in_stall is high meanwhile.
// Configuration writes are taken at any time and apply from the next accepted word.
`default_nettype none

module set_assoc_lru_cache_model #(
  parameter int MAX_WAYS     = 8,
  parameter int MAX_SET_BITS = 6,
  parameter int ADDR_WIDTH   = 64,
  parameter int STAMP_WIDTH  = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [salc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              command,
  input  wire  [ADDR_WIDTH-1:0]            address,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             hit,
  output logic                             evicted,
  output logic                             last,
  output logic [salc_pkg::TOTAL_W-1:0]     hit_total,
  output logic [salc_pkg::TOTAL_W-1:0]     miss_total,
  output logic [salc_pkg::TOTAL_W-1:0]     evict_total
);

  import salc_pkg::*;

  localparam int NUM_LINES = (1 << MAX_SET_BITS) * MAX_WAYS;
  localparam int LINE_W    = $clog2(NUM_LINES);
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int SB_W      = $clog2(MAX_SET_BITS + 1);
  localparam int SET_W     = MAX_SET_BITS;
  localparam int TAG_W     = ADDR_WIDTH - 2;
  localparam int ENTRY_W   = 1 + TAG_W + STAMP_WIDTH;
  localparam logic [STAMP_WIDTH-1:0] STAMP_MAX = {STAMP_WIDTH{1'b1}};

  state_t state, state_next;

  logic [SET_REG_W-1:0]  cfg_set_bits;
  logic [OFF_REG_W-1:0]  cfg_offset_bits;
  logic [WAYS_REG_W-1:0] cfg_ways;

  logic [SB_W-1:0]       sb_eff;
  logic [OFF_REG_W-1:0]  ob_eff;
  logic [WCNT_W-1:0]     nw_eff;

  logic [SB_W-1:0]       sb_q;
  logic [WCNT_W-1:0]     nw_q;
  logic [ADDR_WIDTH-1:0] shifted;
  logic                  modify_q;
  logic                  second_q;
  logic [SET_W-1:0]      set_q;
  logic [TAG_W-1:0]      tag_q;

  logic [WCNT_W-1:0]     scan_way;
  logic                  cmp_on;
  logic [WAY_W-1:0]      cmp_way;
  logic                  issue_left;

  logic                  hit_f;
  logic [WAY_W-1:0]      hit_way;
  logic                  free_f;
  logic [WAY_W-1:0]      free_way;
  logic [WAY_W-1:0]      min_way;
  logic [STAMP_WIDTH-1:0] min_stamp;

  logic [STAMP_WIDTH-1:0] use_clock;
  logic [LINE_W-1:0]      clr_idx;

  logic [ENTRY_W-1:0]    mem [NUM_LINES];
  logic [ENTRY_W-1:0]    rd_data;
  logic [LINE_W-1:0]     mem_raddr;
  logic [LINE_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]    mem_wdata;
  logic                  mem_we;

  logic                  e_valid;
  logic [TAG_W-1:0]      e_tag;
  logic [STAMP_WIDTH-1:0] e_stamp;

  logic                  in_take;
  logic                  slot_free;
  logic                  update_go;
  logic [WAY_W-1:0]      victim_way;

  assign e_valid = rd_data[ENTRY_W-1];
  assign e_tag   = rd_data[ENTRY_W-2 -: TAG_W];
  assign e_stamp = rd_data[STAMP_WIDTH-1:0];

  always_comb begin
    if (cfg_set_bits == '0) begin
      sb_eff = SB_W'(1);
    end else if (cfg_set_bits > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(cfg_set_bits);
    end
    if (cfg_offset_bits < OFFSET_MIN) begin
      ob_eff = OFFSET_MIN;
    end else if (cfg_offset_bits > OFFSET_MAX) begin
      ob_eff = OFFSET_MAX;
    end else begin
      ob_eff = cfg_offset_bits;
    end
    if (cfg_ways == '0) begin
      nw_eff = WCNT_W'(1);
    end else if (cfg_ways > MAX_WAYS) begin
      nw_eff = WCNT_W'(MAX_WAYS);
    end else begin
      nw_eff = WCNT_W'(cfg_ways);
    end
  end

  assign issue_left = scan_way < nw_q;
  assign in_take    = (state == ST_IDLE) && in_valid;
  assign slot_free  = !out_valid || !out_stall;
  assign update_go  = (state == ST_UPDATE) && slot_free;
  assign victim_way = hit_f ? hit_way : (free_f ? free_way : min_way);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_waddr  = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(victim_way);
    mem_wdata  = {1'b1, tag_q, use_clock};
    mem_raddr  = LINE_W'(set_q) * LINE_W'(MAX_WAYS) + LINE_W'(scan_way);
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
        if (clr_idx == LINE_W'(NUM_LINES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue_left && cmp_on) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (slot_free) begin
          mem_we     = 1'b1;
          state_next = (modify_q && !second_q) ? ST_SCAN : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + LINE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_set_bits    <= SET_BITS_RESET;
      cfg_offset_bits <= OFFSET_RESET;
      cfg_ways        <= WAYS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:    cfg_set_bits    <= cfg_data[SET_REG_W-1:0];
        REG_OFFSET_BITS: cfg_offset_bits <= cfg_data[OFF_REG_W-1:0];
        REG_WAYS:        cfg_ways        <= cfg_data[WAYS_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      shifted  <= address >> ob_eff;
      sb_q     <= sb_eff;
      nw_q     <= nw_eff;
      modify_q <= command;
    end
    if (state == ST_SPLIT) begin
      set_q <= SET_W'(shifted) & ~({SET_W{1'b1}} << sb_q);
      tag_q <= TAG_W'(shifted >> sb_q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_way <= '0;
      cmp_on   <= 1'b0;
      second_q <= 1'b0;
    end else begin
      cmp_on <= 1'b0;
      if (state == ST_SPLIT) begin
        scan_way <= '0;
        second_q <= 1'b0;
      end else if (state == ST_SCAN && issue_left) begin
        scan_way <= scan_way + WCNT_W'(1);
        cmp_on   <= 1'b1;
      end else if (update_go) begin
        scan_way <= '0;
        second_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && issue_left) begin
      cmp_way <= scan_way[WAY_W-1:0];
    end
    if (state == ST_SPLIT || update_go) begin
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end else if (state == ST_SCAN && cmp_on) begin
      if (e_valid && e_tag == tag_q && !hit_f) begin
        hit_f   <= 1'b1;
        hit_way <= cmp_way;
      end
      if (!e_valid && !free_f) begin
        free_f   <= 1'b1;
        free_way <= cmp_way;
      end
      if (cmp_way == '0 || e_stamp < min_stamp) begin
        min_way   <= cmp_way;
        min_stamp <= e_stamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      use_clock   <= STAMP_WIDTH'(1);
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
      out_valid   <= 1'b0;
    end else if (update_go) begin
      if (use_clock != STAMP_MAX) begin
        use_clock <= use_clock + STAMP_WIDTH'(1);
      end
      if (hit_f) begin
        if (hit_total != TOTAL_MAX) begin
          hit_total <= hit_total + TOTAL_W'(1);
        end
      end else begin
        if (miss_total != TOTAL_MAX) begin
          miss_total <= miss_total + TOTAL_W'(1);
        end
        if (!free_f && evict_total != TOTAL_MAX) begin
          evict_total <= evict_total + TOTAL_W'(1);
        end
      end
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      hit     <= hit_f;
      evicted <= !hit_f && !free_f;
      last    <= !modify_q || second_q;
    end
  end

endmodule

`default_nettype wire
